// ===== hw/rtl/pih_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pih_pkg
// Shared types and constants of the pulse interval histogram.
// ----------------------------------------------------------------------------
package pih_pkg;

  localparam int TS_W            = 32;
  localparam int IDX_W           = 7;
  localparam int CNT_W           = 16;
  localparam int LL_W            = 14;
  localparam int TOT_W           = 16;
  localparam int CFG_W           = 16;
  localparam int BIN_COUNT_DEF   = 101;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [LL_W-1:0]  LL_RESET  = LL_W'(950);
  localparam logic [TOT_W-1:0] TOT_RESET = TOT_W'(1000);
  localparam logic [CNT_W-1:0] CNT_MAX   = '1;
  localparam logic [TOT_W-1:0] SEEN_MAX  = '1;

  typedef enum logic [1:0] {
    CMD_EDGE  = 2'd0,
    CMD_START = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic {
    REG_WIN_BASE       = 1'b0,
    REG_INTERVAL_TOTAL = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_IDLE  = 2'd0,
    OP_COUNT = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_kind_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [TS_W-1:0]   delta;
    logic [IDX_W-1:0]  idx;
    logic              done;
  } op_t;

endpackage

// ===== hw/rtl/pih_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pih_front
// Run control: alignment, interval count and stop; classifies each beat.
// ----------------------------------------------------------------------------
module pih_front import pih_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [1:0]       cmd,
  input  logic [TS_W-1:0]  timestamp,
  input  logic [IDX_W-1:0] bucket_index,
  input  logic [TOT_W-1:0] interval_total,
  output op_t              op
);

  logic [TS_W-1:0]  prev_stamp, prev_stamp_next;
  logic             aligned, aligned_next;
  logic [TOT_W-1:0] seen, seen_next;
  logic             running, running_next;
  logic [TOT_W-1:0] limit;
  cmd_t             cmd_c;

  assign cmd_c = cmd_t'(cmd);
  assign limit = (interval_total == '0) ? TOT_W'(1) : interval_total;

  always_comb begin
    prev_stamp_next = prev_stamp;
    aligned_next    = aligned;
    seen_next       = seen;
    running_next    = running;
    op.kind         = OP_IDLE;
    op.delta        = timestamp - prev_stamp;
    op.idx          = bucket_index;
    unique case (cmd_c)
      CMD_EDGE: begin
        if (running) begin
          prev_stamp_next = timestamp;
          if (!aligned) begin
            aligned_next = 1'b1;
          end else begin
            op.kind = OP_COUNT;
            if (seen != SEEN_MAX) seen_next = seen + TOT_W'(1);
            if (seen_next >= limit) running_next = 1'b0;
          end
        end
      end
      CMD_START: begin
        op.kind         = OP_CLEAR;
        prev_stamp_next = '0;
        aligned_next    = 1'b0;
        seen_next       = '0;
        running_next    = 1'b1;
      end
      CMD_READ: op.kind = OP_READ;
      CMD_NONE: op.kind = OP_IDLE;
      default:  op.kind = OP_IDLE;
    endcase
    op.done = !running_next && (seen_next != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_stamp <= '0;
      aligned    <= 1'b0;
      seen       <= '0;
      running    <= 1'b0;
    end else if (accept) begin
      prev_stamp <= prev_stamp_next;
      aligned    <= aligned_next;
      seen       <= seen_next;
      running    <= running_next;
    end
  end

endmodule

// ===== hw/rtl/pih_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pih_queue
// Short FIFO of classified operations between front and back.
// ----------------------------------------------------------------------------
module pih_queue import pih_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output op_t  head
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  op_t           slots [QUEUE_DEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full       = (count == CW'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= (wptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr + PW'(1);
      if (do_pop)  rptr <= (rptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr + PW'(1);
      if (do_push && !do_pop) count <= count + CW'(1);
      else if (do_pop && !do_push) count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wptr] <= push_op;
  end

endmodule

// ===== hw/rtl/pih_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pih_back
// Bucket memory pipeline: window check, read, saturating update, result beat.
// ----------------------------------------------------------------------------
module pih_back import pih_pkg::*; #(
  parameter int BIN_COUNT = BIN_COUNT_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [LL_W-1:0]  win_base,
  input  logic             head_valid,
  input  op_t              head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [CNT_W-1:0] bucket_value,
  output logic             in_window,
  output logic             run_done
);

  localparam int AW = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
  localparam int XW = ((AW > IDX_W) ? AW : IDX_W) + 1;

  logic [CNT_W-1:0] mem [BIN_COUNT];
  logic [CNT_W-1:0] mem_q;
  logic [BIN_COUNT-1:0] vbit;

  // window check on queue head
  logic [TS_W-1:0] off;
  logic [XW-1:0]   idx_x;
  logic            hit1, rd_ok1;
  logic [AW-1:0]   addr1;

  assign off    = head.delta - TS_W'(win_base);
  assign hit1   = (head.delta >= TS_W'(win_base)) && (off < TS_W'(BIN_COUNT));
  assign idx_x  = XW'(head.idx);
  assign rd_ok1 = (idx_x < XW'(BIN_COUNT));

  always_comb begin
    if (head.kind == OP_COUNT) addr1 = hit1 ? off[AW-1:0] : '0;
    else                       addr1 = rd_ok1 ? idx_x[AW-1:0] : '0;
  end

  // update stage
  logic          b2_valid;
  op_kind_t      b2_kind;
  logic [AW-1:0] b2_addr;
  logic          b2_hit, b2_rd_ok, b2_done;
  logic          out_free, b2_go, wr_en;
  logic [CNT_W-1:0] cur, inc;

  // last write, for a read issued in the same cycle as that write
  logic             lw_valid;
  logic [AW-1:0]    lw_addr;
  logic [CNT_W-1:0] lw_data;

  assign out_free = !out_valid || !out_stall;
  assign b2_go    = b2_valid && out_free;
  assign pop      = head_valid && (!b2_valid || out_free);

  always_comb begin
    if (lw_valid && lw_addr == b2_addr) cur = lw_data;
    else if (vbit[b2_addr])             cur = mem_q;
    else                                cur = '0;
    inc   = (cur == CNT_MAX) ? cur : cur + CNT_W'(1);
    wr_en = b2_go && (b2_kind == OP_COUNT) && b2_hit;
  end

  always_ff @(posedge clk) begin
    if (pop) mem_q <= mem[addr1];
    if (wr_en) mem[b2_addr] <= inc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b2_valid  <= 1'b0;
      vbit      <= '0;
      lw_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop)        b2_valid <= 1'b1;
      else if (b2_go) b2_valid <= 1'b0;
      if (b2_go) begin
        if (b2_kind == OP_CLEAR) begin
          vbit     <= '0;
          lw_valid <= 1'b0;
        end else if (wr_en) begin
          vbit[b2_addr] <= 1'b1;
          lw_valid      <= 1'b1;
        end
      end
      if (out_free) out_valid <= b2_go;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b2_kind  <= head.kind;
      b2_addr  <= addr1;
      b2_hit   <= hit1;
      b2_rd_ok <= rd_ok1;
      b2_done  <= head.done;
    end
    if (wr_en) begin
      lw_addr <= b2_addr;
      lw_data <= inc;
    end
    if (b2_go) begin
      bucket_value <= (b2_kind == OP_READ && b2_rd_ok) ? cur : '0;
      in_window    <= (b2_kind == OP_COUNT) && b2_hit;
      run_done     <= b2_done;
    end
  end

endmodule

// ===== hw/rtl/pulse_interval_histogram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_interval_histogram
// Histogram of intervals between timestamped edges, with run control.
//
//   channel  signals                                   dir
//   in       in_valid/in_stall, cmd, timestamp,         in
//            bucket_index
//   out      out_valid/out_stall, bucket_value,         out
//            in_window, run_done
//   cfg      cfg_we, cfg_index, cfg_data                in
//
// One beat per cycle sustained while out_stall is low; a result beat is offered
// after its input beat has passed the queue slot and then the update stage
// behind the registered bucket memory read. Bucket memory with one read and
// one write port, and write forwarding. rst clears control state; buckets
// read as zero through per-bucket valid flags, so there is no clearing pass.
// out_stall backs up through the queue to in_stall.
// ----------------------------------------------------------------------------
module pulse_interval_histogram import pih_pkg::*; #(
  parameter int BIN_COUNT = BIN_COUNT_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       cmd,
  input  logic [TS_W-1:0]  timestamp,
  input  logic [IDX_W-1:0] bucket_index,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [CNT_W-1:0] bucket_value,
  output logic             in_window,
  output logic             run_done,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  logic [LL_W-1:0]  win_base;
  logic [TOT_W-1:0] interval_total;
  logic             accept, full, head_valid, pop;
  op_t              front_op, head;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_base       <= LL_RESET;
      interval_total <= TOT_RESET;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_WIN_BASE:       win_base       <= cfg_data[LL_W-1:0];
        REG_INTERVAL_TOTAL: interval_total <= cfg_data[TOT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  pih_front u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .cmd            (cmd),
    .timestamp      (timestamp),
    .bucket_index   (bucket_index),
    .interval_total (interval_total),
    .op             (front_op)
  );

  pih_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_op    (front_op),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  pih_back #(
    .BIN_COUNT (BIN_COUNT)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .win_base     (win_base),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .bucket_value (bucket_value),
    .in_window    (in_window),
    .run_done     (run_done)
  );

`ifndef ASSERT_OFF
  a_window_no_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && in_window |-> bucket_value == '0)
    else $error("counted edge carries a bucket value");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat right after reset");

  a_full_has_head: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> head_valid)
    else $error("queue full without a head entry");
`endif

endmodule
